// ===== hw/rtl/quadtree_image_encoder_assert.svh =====
// Assertion macros for the quadtree encoder sequencer RTL; they expect clk and arst_n in scope.
`ifndef QUADTREE_IMAGE_ENCODER_ASSERT_SVH
`define QUADTREE_IMAGE_ENCODER_ASSERT_SVH
// Condition that must hold on every clock edge out of reset.
`define QIE_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("qie: invariant violated");
// Condition that must hold whenever the antecedent holds.
`define QIE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qie: implication violated");
`endif

// ===== hw/rtl/qie_pkg.sv =====
// Shared types, codes and helpers for the quadtree image encoder.
`default_nettype none
package qie_pkg;
	localparam int MAX_SIDE_DEF = 64;
	localparam int REG_SIDE_LOG2 = 0;
	localparam logic [2:0] SIDE_LOG2_RESET = 3'd6;
	localparam logic [1:0] SUM_MIXED = 2'd2;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      pixel;
	} cmd_item_t;

	typedef enum logic [1:0] {
		TK_ZERO  = 2'd0,
		TK_ONE   = 2'd1,
		TK_OPEN  = 2'd2,
		TK_CLOSE = 2'd3
	} token_t;

	typedef enum logic [1:0] {
		PH_LOADING = 2'd0,
		PH_ENTER   = 2'd1,
		PH_CLOSE   = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	// Start of pyramid level d in the node memory: (4^d - 1) / 3.
	function automatic int unsigned level_offset(input logic [3:0] d);
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < 9; i++) begin
			if (4'(i) < d) begin
				acc = (acc << 2) + 1;
			end
		end
		return acc;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/qie_front.sv =====
// Input side: takes command beats, tags their kind and queues them for the sequencer.
`default_nettype none
module qie_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              s_tuser,   // [0] cmd
	input  wire logic [7:0]        s_tdata,   // [0] pixel
	output logic                   deq_valid,
	output qie_pkg::cmd_item_t     deq_item,
	input  wire logic              deq_pop
);
	localparam int QDEPTH = 2;

	qie_pkg::cmd_item_t q_mem_q [QDEPTH];
	logic               wp_q, rp_q;
	logic [1:0]         cnt_q;
	logic               push;
	qie_pkg::cmd_item_t in_item;

	assign s_tready      = (cnt_q != 2'(QDEPTH));
	assign push          = s_tvalid && s_tready;
	assign deq_valid     = (cnt_q != 2'd0);
	assign deq_item      = q_mem_q[rp_q];
	assign in_item.kind  = qie_pkg::cmd_kind_t'(s_tuser);
	assign in_item.pixel = s_tdata[0];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (deq_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !deq_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && deq_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/qie_back.sv =====
// Sequencer: pixel store, pyramid build, preorder walk and the output register.
`default_nettype none
`include "quadtree_image_encoder_assert.svh"
module qie_back #(
	parameter int MAX_SIDE = qie_pkg::MAX_SIDE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [2:0]         side_log2,
	input  wire logic               cfg_restart,
	input  wire logic               deq_valid,
	input  qie_pkg::cmd_item_t      deq_item,
	output logic                    deq_pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tuser,
	output logic                    m_tlast
);
	localparam int LOG_MAX = $clog2(MAX_SIDE);
	localparam int LVW     = $clog2(LOG_MAX + 1);
	localparam int CW      = LOG_MAX;
	localparam int SIW     = (LOG_MAX > 1) ? $clog2(LOG_MAX) : 1;
	localparam int DEPTH   = int'(qie_pkg::level_offset(4'(LOG_MAX + 1)));
	localparam int AW      = $clog2(DEPTH);
	localparam int CNTW    = 2 * LOG_MAX + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_BUILD = 4'b0010,
		S_BFIN  = 4'b0100,
		S_WREAD = 4'b1000
	} state_t;

	state_t            state_q;
	qie_pkg::phase_t   phase_q;
	logic [CNTW-1:0]   load_cnt_q;
	logic [LVW-1:0]    lvl_q;
	logic [CW-1:0]     row_q, col_q;
	logic [1:0]        stk_q [LOG_MAX];

	logic [LVW-1:0]    bd_q;
	logic [CW-1:0]     br_q, bc_q;
	logic [1:0]        bk_q;
	logic              rd_s1;
	logic [1:0]        k_s1;
	logic [AW-1:0]     waddr_s1;
	logic [1:0]        first_q;
	logic              mix_q;

	logic [1:0]        mem [DEPTH];
	logic [1:0]        rdata_q;

	logic              ov_q;
	qie_pkg::token_t   otok_q;
	logic              oval_q, olast_q;

	logic [LVW-1:0]    lg;
	logic [CNTW-1:0]   ld_base, ld_next, total;
	logic [AW-1:0]     ld_addr, walk_addr, ch_addr, nd_addr, waddr, raddr;
	logic [LVW-1:0]    bd1;
	logic [CW-1:0]     lastd;
	logic              we, re;
	logic [1:0]        wdata, bwval;
	logic              is_fetch;

	logic [LVW-1:0]    lvl_m1;
	logic [SIW-1:0]    adv_idx;
	logic [1:0]        adv_k, adv_kn;
	logic              adv_done, adv_step;
	logic              wr_open;

	assign lg = (int'(side_log2) > LOG_MAX) ? LVW'(LOG_MAX) : LVW'(side_log2);

	assign deq_pop  = deq_valid && (state_q == S_IDLE) && (!ov_q || m_tready);
	assign is_fetch = (deq_item.kind == qie_pkg::CMD_FETCH);

	assign ld_base   = (phase_q == qie_pkg::PH_LOADING) ? load_cnt_q : '0;
	assign ld_next   = ld_base + CNTW'(1);
	assign total     = CNTW'(1) << {lg, 1'b0};
	assign ld_addr   = AW'(qie_pkg::level_offset(4'(lg))) + AW'(ld_base);
	assign walk_addr = AW'(qie_pkg::level_offset(4'(lvl_q))) + (AW'(row_q) << lvl_q)
		+ AW'(col_q);

	// Child k of build node (bd, br, bc) sits one level down at (2br+k/2, 2bc+k%2).
	assign bd1     = bd_q + LVW'(1);
	assign ch_addr = AW'(qie_pkg::level_offset(4'(bd1))) + (AW'({br_q, bk_q[1]}) << bd1)
		+ AW'({bc_q, bk_q[0]});
	assign nd_addr = AW'(qie_pkg::level_offset(4'(bd_q))) + (AW'(br_q) << bd_q) + AW'(bc_q);
	assign lastd   = CW'((32'd1 << bd_q) - 32'd1);
	assign bwval   = (mix_q || (rdata_q != first_q)) ? qie_pkg::SUM_MIXED : first_q;

	always_comb begin
		we    = 1'b0;
		waddr = ld_addr;
		wdata = {1'b0, deq_item.pixel};
		if (deq_pop && !is_fetch) begin
			we = 1'b1;
		end else if (rd_s1 && (k_s1 == 2'd3)) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = bwval;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = ch_addr;
		if (state_q == S_BUILD) begin
			re = 1'b1;
		end else if (deq_pop && is_fetch && (phase_q == qie_pkg::PH_ENTER)) begin
			re    = 1'b1;
			raddr = walk_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Step past the finished node: next sibling, or climb and close the parent, or finish at the root.
	assign lvl_m1   = lvl_q - LVW'(1);
	assign adv_idx  = lvl_m1[SIW-1:0];
	assign adv_k    = stk_q[adv_idx];
	assign adv_kn   = adv_k + 2'd1;
	assign adv_done = (lvl_q == '0);
	assign adv_step = (adv_k != 2'd3);
	assign wr_open  = (rdata_q == qie_pkg::SUM_MIXED) && (lvl_q < lg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= qie_pkg::PH_LOADING;
			load_cnt_q <= '0;
			lvl_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			for (int i = 0; i < LOG_MAX; i++) begin
				stk_q[i] <= 2'd0;
			end
			bd_q       <= '0;
			br_q       <= '0;
			bc_q       <= '0;
			bk_q       <= 2'd0;
			rd_s1      <= 1'b0;
			k_s1       <= 2'd0;
			waddr_s1   <= '0;
			first_q    <= 2'd0;
			mix_q      <= 1'b0;
			ov_q       <= 1'b0;
			otok_q     <= qie_pkg::TK_ZERO;
			oval_q     <= 1'b0;
			olast_q    <= 1'b0;
		end else begin
			if (m_tready) begin
				ov_q <= 1'b0;
			end
			rd_s1    <= (state_q == S_BUILD);
			k_s1     <= bk_q;
			waddr_s1 <= nd_addr;
			if (rd_s1) begin
				if (k_s1 == 2'd0) begin
					first_q <= rdata_q;
					mix_q   <= 1'b0;
				end else begin
					mix_q <= mix_q || (rdata_q != first_q);
				end
			end

			if (cfg_restart) begin
				load_cnt_q <= '0;
				phase_q    <= qie_pkg::PH_LOADING;
				lvl_q      <= '0;
				row_q      <= '0;
				col_q      <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (deq_pop && !is_fetch) begin
							load_cnt_q <= ld_next;
							phase_q    <= qie_pkg::PH_LOADING;
							lvl_q      <= '0;
							row_q      <= '0;
							col_q      <= '0;
							if (ld_next >= total) begin
								if (lg == '0) begin
									phase_q <= qie_pkg::PH_ENTER;
								end else begin
									state_q <= S_BUILD;
									bd_q    <= lg - LVW'(1);
									br_q    <= '0;
									bc_q    <= '0;
									bk_q    <= 2'd0;
								end
							end
						end else if (deq_pop) begin
							unique case (phase_q)
								qie_pkg::PH_ENTER: begin
									state_q <= S_WREAD;
								end
								qie_pkg::PH_CLOSE: begin
									ov_q    <= 1'b1;
									otok_q  <= qie_pkg::TK_CLOSE;
									oval_q  <= 1'b1;
									olast_q <= adv_done;
									if (adv_done) begin
										phase_q <= qie_pkg::PH_DONE;
									end else if (adv_step) begin
										stk_q[adv_idx] <= adv_kn;
										row_q   <= (row_q & ~CW'(1)) | CW'(adv_kn[1]);
										col_q   <= (col_q & ~CW'(1)) | CW'(adv_kn[0]);
										phase_q <= qie_pkg::PH_ENTER;
									end else begin
										lvl_q   <= lvl_m1;
										row_q   <= row_q >> 1;
										col_q   <= col_q >> 1;
										phase_q <= qie_pkg::PH_CLOSE;
									end
								end
								default: begin
									ov_q    <= 1'b1;
									otok_q  <= qie_pkg::TK_ZERO;
									oval_q  <= 1'b0;
									olast_q <= 1'b0;
								end
							endcase
						end
					end
					S_BUILD: begin
						bk_q <= bk_q + 2'd1;
						if (bk_q == 2'd3) begin
							if (bc_q == lastd) begin
								bc_q <= '0;
								if (br_q == lastd) begin
									br_q <= '0;
									if (bd_q == '0) begin
										state_q <= S_BFIN;
									end else begin
										bd_q <= bd_q - LVW'(1);
									end
								end else begin
									br_q <= br_q + CW'(1);
								end
							end else begin
								bc_q <= bc_q + CW'(1);
							end
						end
					end
					S_BFIN: begin
						// root summary is written this cycle
						phase_q <= qie_pkg::PH_ENTER;
						lvl_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						state_q <= S_IDLE;
					end
					S_WREAD: begin
						state_q <= S_IDLE;
						ov_q    <= 1'b1;
						oval_q  <= 1'b1;
						if (wr_open) begin
							otok_q  <= qie_pkg::TK_OPEN;
							olast_q <= 1'b0;
							stk_q[lvl_q[SIW-1:0]] <= 2'd0;
							lvl_q   <= lvl_q + LVW'(1);
							row_q   <= row_q << 1;
							col_q   <= col_q << 1;
						end else begin
							otok_q  <= qie_pkg::token_t'({1'b0, rdata_q[0]});
							olast_q <= adv_done;
							if (adv_done) begin
								phase_q <= qie_pkg::PH_DONE;
							end else if (adv_step) begin
								stk_q[adv_idx] <= adv_kn;
								row_q   <= (row_q & ~CW'(1)) | CW'(adv_kn[1]);
								col_q   <= (col_q & ~CW'(1)) | CW'(adv_kn[0]);
								phase_q <= qie_pkg::PH_ENTER;
							end else begin
								lvl_q   <= lvl_m1;
								row_q   <= row_q >> 1;
								col_q   <= col_q >> 1;
								phase_q <= qie_pkg::PH_CLOSE;
							end
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, otok_q};
	assign m_tuser  = oval_q;
	assign m_tlast  = olast_q;

	`QIE_ASSERT_IMPL(a_wread_slot_free, state_q == S_WREAD, !ov_q)
	`QIE_ASSERT_IMPL(a_build_in_loading, state_q == S_BUILD, phase_q == qie_pkg::PH_LOADING)
	`QIE_ASSERT(a_walk_depth, lvl_q <= lg)
endmodule
`default_nettype wire

// ===== hw/rtl/quadtree_image_encoder.sv =====
// Quadtree image encoder top level: register port, command queue and sequencer.
`default_nettype none
// Load a 2^L x 2^L binary image with cmd=0 beats (one pixel each, raster order, one cycle
// per beat), then pull the quadtree code with cmd=1 beats, one token per result beat. After
// the final pixel the block builds its node pyramid in the node memory (one read port, one
// write port) with four reads per interior node; it pops no command beat while it builds. A
// token read from a node (digit or open mark) takes a memory read, then a decision; close
// marks and invalid tokens need no read. Writing side_log2 restarts loading; values above
// log2(MAX_SIDE) are clamped to it.
module quadtree_image_encoder #(
	parameter int MAX_SIDE = qie_pkg::MAX_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic        s_tuser,   // [0] cmd
	input  wire logic [7:0]  s_tdata,   // [0] pixel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [1:0] token
	output logic             m_tuser,   // [0] token_valid
	output logic             m_tlast
);
	logic [2:0]         side_q;
	logic               reg_hit, cfg_restart;
	logic               deq_valid, deq_pop;
	qie_pkg::cmd_item_t deq_item;

	assign pready      = 1'b1;
	assign reg_hit     = (paddr[2:2] == 1'(qie_pkg::REG_SIDE_LOG2));
	assign cfg_restart = psel && penable && pwrite && pready && reg_hit;
	assign prdata      = reg_hit ? {29'd0, side_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= qie_pkg::SIDE_LOG2_RESET;
		end else if (cfg_restart) begin
			side_q <= pwdata[2:0];
		end
	end

	qie_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.deq_valid (deq_valid),
		.deq_item  (deq_item),
		.deq_pop   (deq_pop)
	);

	qie_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_log2   (side_q),
		.cfg_restart (cfg_restart),
		.deq_valid   (deq_valid),
		.deq_item    (deq_item),
		.deq_pop     (deq_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);
endmodule
`default_nettype wire
